// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int OCC_W           = 5;

  // Opcodes of an input word
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/spq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire logic               occupied,
  input  wire logic               left_after,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t         entry,
  output logic                    after
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // New word sorts behind this slot (ties keep arrival order)
  assign after = occupied && (entry_r.prio <= ctl.new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (after) begin
        entry_nxt = entry_r;
      end else if (left_after) begin
        entry_nxt = ctl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue_unit.sv =====
// Top level: bounded sorted priority queue built as a row of shifting cells.
// Latency: one result word per accepted word, strobed on out_valid in the cycle after accept.
// Throughput: one word per cycle; every cell compares and shifts in the same edge.
// busy is held low, so start is taken in any cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the queue and clears the strobe;
// slot contents are left as they are and are never read until rewritten.
`default_nettype none
module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_opcode,
  input  wire logic signed [spq_pkg::DATA_W-1:0] in_item_value,
  input  wire logic signed [spq_pkg::DATA_W-1:0] in_item_priority,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic signed [spq_pkg::DATA_W-1:0]      out_out_value,
  output logic signed [spq_pkg::DATA_W-1:0]      out_out_priority,
  output logic [spq_pkg::OCC_W-1:0]              out_occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Entry count
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  logic             empty;
  logic             accept;
  logic             do_ins;
  logic             do_rem;

  // Result registers
  logic                              valid_r;
  spq_pkg::status_t                  status_r;
  spq_pkg::status_t                  status_nxt;
  logic signed [spq_pkg::DATA_W-1:0] value_r;
  logic signed [spq_pkg::DATA_W-1:0] prio_r;
  logic [spq_pkg::OCC_W-1:0]         occ_r;

  // Cell row
  spq_pkg::cell_ctl_t    ctl;
  spq_pkg::entry_t       cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] after_w;
  logic [QUEUE_DEPTH-1:0] occ_w;

  // Every cell updates at the edge that takes the word, so a word is never held off.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign do_ins = accept && (in_opcode == spq_pkg::OP_INSERT) && !full;
  assign do_rem = accept && (in_opcode == spq_pkg::OP_REMOVE) && !empty;

  assign ctl.ins             = do_ins;
  assign ctl.rem             = do_rem;
  assign ctl.new_entry.value = in_item_value;
  assign ctl.new_entry.prio  = in_item_priority;

  // Cell i holds a live entry when it sits below the count; entries stay
  // packed at the front in ascending priority, so the "after" flags form a
  // prefix and the first cell without it takes the new word.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_a;

    assign occ_w[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_e = ctl.new_entry;
      assign left_a = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_a = after_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ_w[i]),
      .left_after  (left_a),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .after       (after_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    if (in_opcode == spq_pkg::OP_INSERT) begin
      status_nxt = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_INSERTED;
    end else begin
      status_nxt = empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_REMOVED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  // Payload of the result word; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= do_rem ? cell_entry[0].value : '0;
      prio_r   <= do_rem ? cell_entry[0].prio : '0;
      occ_r    <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_out_value    = value_r;
  assign out_out_priority = prio_r;
  assign out_occupancy    = occ_r;

  // Insert position flags must form a prefix of the row
  a_after_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((after_w + 1'b1) & after_w) == '0)
    else $error("insert position flags not contiguous");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    occ_w[1] |-> (cell_entry[0].prio <= cell_entry[1].prio))
    else $error("front entries out of order");

  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_rem |=> (count_r == $past(count_r) - 1'b1))
    else $error("remove did not drop the count");

  a_result_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W       = spq_pkg::DATA_W;
  localparam int OCC_W        = spq_pkg::OCC_W;
  localparam int DEPTH        = spq_pkg::QUEUE_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1400;

  localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'h7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'h8000_0000;

  typedef spq_pkg::status_t status_t;

  // One result word as the block strobes it out
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic [OCC_W-1:0]         occ;
  } result_t;

  // Directed table row; reps > 1 sends a run of inserts with stepped value and priority
  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic [4:0]               reps;
    logic                     golden;
    result_t                  want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic                     in_opcode        = spq_pkg::OP_INSERT;
  logic signed [DATA_W-1:0] in_item_value    = '0;
  logic signed [DATA_W-1:0] in_item_priority = '0;

  // Hand-typed expectation travelling with the word on the input side
  logic    word_golden = 1'b0;
  result_t word_want   = '0;

  logic                     busy;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_out_value;
  logic signed [DATA_W-1:0] out_out_priority;
  logic [OCC_W-1:0]         out_occupancy;

  sorted_priority_queue_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_out_value    (out_out_value),
    .out_out_priority (out_out_priority),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow queue: sorted by priority, ties kept in arrival order
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] held_value [DEPTH];
  logic signed [DATA_W-1:0] held_prio  [DEPTH];
  int                       held_count = 0;

  result_t   awaited_results [$];
  stim_row_t directed_rows   [$];
  int        error_count = 0;
  int        burst_left  = 1;

  // Applies one word to the shadow queue and returns the result word it should cause
  function automatic result_t step_sorted_queue(input logic op,
                                                input logic signed [DATA_W-1:0] val,
                                                input logic signed [DATA_W-1:0] pri);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // new pair lands behind every entry with priority <= its own
        pos = 0;
        while (pos < held_count && held_prio[pos] <= pri) pos++;
        for (i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = val;
        held_prio[pos]  = pri;
        held_count++;
        r.status = spq_pkg::ST_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        r.value  = held_value[0];
        r.prio   = held_prio[0];
        r.status = spq_pkg::ST_REMOVED;
        for (i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_prio[i-1]  = held_prio[i];
        end
        held_count--;
      end
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Compare the strobed word against the oldest awaited result, field by field
  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result word strobed with nothing awaited");
    end else begin
      want = awaited_results.pop_front();
      if (out_status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
      if (out_out_value !== want.value)
        report_mismatch($sformatf("value got %0d want %0d", out_out_value, want.value));
      if (out_out_priority !== want.prio)
        report_mismatch($sformatf("priority got %0d want %0d", out_out_priority, want.prio));
      if (out_occupancy !== want.occ)
        report_mismatch($sformatf("occupancy got %0d want %0d", out_occupancy, want.occ));
    end
  endtask

  // Monitor: everything sampled at the rising edge, before the block's own updates land.
  // The result strobed now belongs to an earlier accepted word, so check before push.
  always @(posedge clk) begin : monitor
    result_t predicted;
    if (rst_n) begin
      if (out_valid === 1'b1) check_result();
      if (start && busy === 1'b0) begin
        predicted = step_sorted_queue(in_opcode, in_item_value, in_item_priority);
        awaited_results.push_back(word_golden ? word_want : predicted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------
  function automatic stim_row_t make_row(input logic op,
                                         input logic signed [DATA_W-1:0] val,
                                         input logic signed [DATA_W-1:0] pri,
                                         input int reps, input logic golden,
                                         input status_t st,
                                         input logic signed [DATA_W-1:0] rv,
                                         input logic signed [DATA_W-1:0] rp,
                                         input int occ);
    stim_row_t row;
    row.op          = op;
    row.value       = val;
    row.prio        = pri;
    row.reps        = 5'(reps);
    row.golden      = golden;
    row.want.status = st;
    row.want.value  = rv;
    row.want.prio   = rp;
    row.want.occ    = OCC_W'(occ);
    return row;
  endfunction

  // Present one word and hold it until the edge that takes it
  task automatic send_word(input logic op, input logic signed [DATA_W-1:0] val,
                           input logic signed [DATA_W-1:0] pri,
                           input logic golden, input result_t want);
    start            <= 1'b1;
    in_opcode        <= op;
    in_item_value    <= val;
    in_item_priority <= pri;
    word_golden      <= golden;
    word_want        <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Settle on a falling edge so the monitor has run, then realign to a rising edge
  task automatic wait_drained();
    do @(negedge clk); while (awaited_results.size() != 0);
    @(posedge clk);
  endtask

  // Burst pacing: short or long bursts, then a random gap (often none).
  // drain=1 parks the sender until every awaited result has come back.
  task automatic pace(input bit drain);
    int gap;
    if (drain) begin
      start <= 1'b0;
      wait_drained();
    end else begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 20);
      end
    end
  endtask

  // Priority mix: narrow band for ties, the extremes, and full range
  function automatic logic signed [DATA_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'($urandom_range(0, 5)) - 2;
      4: begin
        case ($urandom_range(0, 3))
          0: return PRIO_MIN;
          1: return PRIO_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t row;
    int        k;
    int        sent;
    int        seg_len;
    int        ins_pct;
    logic      op;

    // Directed table: expectations typed in only where obvious at a glance
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 0, 0, 1, 1,
                                     spq_pkg::ST_UNDERFLOW, 0, 0, 0));
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, PRIO_MAX, PRIO_MAX, 1, 1,
                                     spq_pkg::ST_INSERTED, 0, 0, 1));
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, PRIO_MIN, PRIO_MIN, 1, 1,
                                     spq_pkg::ST_INSERTED, 0, 0, 2));
    // most negative priority jumps ahead of the most positive
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 0, 0, 1, 1, spq_pkg::ST_REMOVED,
                                     PRIO_MIN, PRIO_MIN, 1));
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, -1, -1, 1, 1,
                                     spq_pkg::ST_INSERTED, 0, 0, 2));
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, 0, 0, 1, 1,
                                     spq_pkg::ST_INSERTED, 0, 0, 3));
    // equal priority: 5 must leave after 0
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, 5, 0, 1, 1,
                                     spq_pkg::ST_INSERTED, 0, 0, 4));
    // remove ignores the payload fields
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                                     1, 1, spq_pkg::ST_REMOVED, -1, -1, 3));
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 0, 0, 1, 1,
                                     spq_pkg::ST_REMOVED, 0, 0, 2));
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 0, 0, 1, 1,
                                     spq_pkg::ST_REMOVED, 5, 0, 1));
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 0, 0, 1, 1, spq_pkg::ST_REMOVED,
                                     PRIO_MAX, PRIO_MAX, 0));
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, -1, -1, 1, 1,
                                     spq_pkg::ST_UNDERFLOW, 0, 0, 0));
    // fill to the brim with stepped priorities and repeated ties
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, 1000, -100, DEPTH, 0,
                                     spq_pkg::ST_INSERTED, 0, 0, 0));
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, 77, PRIO_MIN, 1, 1,
                                     spq_pkg::ST_OVERFLOW, 0, 0, DEPTH));
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, -77, PRIO_MAX, 1, 1,
                                     spq_pkg::ST_OVERFLOW, 0, 0, DEPTH));
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 0, 0, 1, 0,
                                     spq_pkg::ST_REMOVED, 0, 0, 0));
    directed_rows.push_back(make_row(spq_pkg::OP_INSERT, 7, PRIO_MIN, 1, 0,
                                     spq_pkg::ST_INSERTED, 0, 0, 0));
    directed_rows.push_back(make_row(spq_pkg::OP_REMOVE, 0, 0, 1, 0,
                                     spq_pkg::ST_REMOVED, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (k = 0; k < row.reps; k++) begin
        send_word(row.op, row.value + k, row.prio - (k % 4), row.golden, row.want);
        pace(1'b0);
      end
    end

    // Random traffic in segments with a biased mix so the queue swings between
    // empty and full; the payload of removes is random too and must be ignored.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      seg_len = $urandom_range(16, 80);
      case ($urandom_range(0, 2))
        0:       ins_pct = 25;
        1:       ins_pct = 50;
        default: ins_pct = 80;
      endcase
      for (k = 0; k < seg_len && sent < RANDOM_WORDS; k++) begin
        op = ($urandom_range(1, 100) <= ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        send_word(op, $urandom, pick_priority(), 1'b0, '0);
        sent++;
        pace(sent == RANDOM_WORDS / 2);
      end
    end

    start <= 1'b0;
    wait_drained();
    // idle on to catch any stray strobe
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_unit.sv
test/testbench.sv
